// ===== rtl/core/marker_packet_deframer_top_defines.svh =====
// ----------------------------------------------------------------------------
// Marker packet deframer assertion macros
// Concurrent checks that are compiled only for simulation.
// ----------------------------------------------------------------------------
`ifndef MARKER_PACKET_DEFRAMER_TOP_DEFINES_SVH
`define MARKER_PACKET_DEFRAMER_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on the rising clock edge.
`define MPD_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("deframer check failed");

// Next-cycle implication, sampled on the rising clock edge.
`define MPD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("deframer check failed");

`else

`define MPD_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define MPD_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/core/mpd_pkg.sv =====
// ----------------------------------------------------------------------------
// Marker packet deframer package
// Sizes, result kinds, marker characters and shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package mpd_pkg;

   localparam int MAX_PAYLOAD = 64;
   localparam int CNT_W       = $clog2(MAX_PAYLOAD + 1);
   localparam int ADDR_W      = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

   typedef logic [1:0] kind_type;
   typedef logic [7:0] byte_type;

   localparam kind_type KIND_BYTE     = 2'd0;
   localparam kind_type KIND_EMPTY    = 2'd1;
   localparam kind_type KIND_TOO_LONG = 2'd2;

   localparam byte_type CHAR_Z     = 8'h5A;
   localparam byte_type CHAR_F     = 8'h46;
   localparam byte_type CHAR_SPACE = 8'h20;
   localparam byte_type CHAR_TAB   = 8'h09;

   function automatic logic is_blank(input byte_type b);
      return (b == CHAR_SPACE) || (b == CHAR_TAB);
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/mpd_req_if.sv =====
// ----------------------------------------------------------------------------
// Deframer request channel
// Valid/ready channel carrying one received byte per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface mpd_req_if;
   logic              valid;
   logic              ready;
   mpd_pkg::byte_type rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/mpd_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Deframer response channel
// Valid/ready channel carrying one payload byte or packet status per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface mpd_rsp_if;
   logic              valid;
   logic              ready;
   mpd_pkg::kind_type kind;
   mpd_pkg::byte_type payload_byte;
   logic              last;

   modport source (output valid, output kind, output payload_byte, output last, input ready);
   modport sink   (input valid, input kind, input payload_byte, input last, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/marker_packet_deframer_top.sv =====
// ----------------------------------------------------------------------------
// Marker packet deframer
// Finds "ZZ" headers and "FF" trailers in a byte stream, buffers the payload
// in a single-port memory and replays it with blanks trimmed from both ends.
// ----------------------------------------------------------------------------
// Usage:
//   req_if carries one received byte per beat; rsp_if returns payload bytes
//   (kind 0, last set on the final one), one empty-packet beat (kind 1) or one
//   too-long beat (kind 2). A packet's beats all carry the trailer's last mark
//   on the final beat only.
//   A payload byte that follows a held-back 'F' is written from ST_WR2 after
//   the 'F', since both bytes go through the one memory write port. After the
//   trailer, each payload byte is read from the synchronous memory in ST_RD
//   and then loaded into the output register in ST_OUT. No new byte is taken
//   while a packet is replayed. Empty-packet and too-long beats are valid in
//   the cycle after the causing byte is taken; the first payload beat of a
//   packet follows ST_RD and ST_OUT.
//   Blank trimming costs nothing at replay time: the first and last non-blank
//   positions are tracked as bytes are written.
//   Reset clears the framing state and the output valid flag; the payload
//   memory needs no clearing, as only written entries are read.
//   When the receiver stalls, a finished result waits in the output register;
//   req_if.ready stays low and replay pauses until that beat is taken.
// ----------------------------------------------------------------------------
`default_nettype none

`include "marker_packet_deframer_top_defines.svh"

module marker_packet_deframer_top (
   input  wire logic clock,
   input  wire logic reset,
   mpd_req_if.sink   req_if,
   mpd_rsp_if.source rsp_if
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_WR2  = 2'd1;
   localparam logic [1:0] ST_RD   = 2'd2;
   localparam logic [1:0] ST_OUT  = 2'd3;

   localparam int CNT_W  = mpd_pkg::CNT_W;
   localparam int ADDR_W = mpd_pkg::ADDR_W;

   logic [1:0]         state_ff, state_in;
   logic               in_payload_ff, in_payload_in;
   logic               hdr_half_ff, hdr_half_in;
   logic               trl_half_ff, trl_half_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               seen_ff, seen_in;
   logic [ADDR_W-1:0]  first_ff, first_in;
   logic [ADDR_W-1:0]  last_ff, last_in;
   logic [ADDR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   mpd_pkg::byte_type  hold_ff, hold_in;
   mpd_pkg::byte_type  rd_data_ff;

   logic               rsp_valid_ff;
   mpd_pkg::kind_type  rsp_kind_ff;
   mpd_pkg::byte_type  rsp_byte_ff;
   logic               rsp_last_ff;

   mpd_pkg::byte_type  payload_mem [mpd_pkg::MAX_PAYLOAD];

   logic               out_free;
   logic               accept;
   mpd_pkg::byte_type  rx;
   logic [CNT_W:0]     need_one;
   logic [CNT_W:0]     need_two;
   logic               too_long;
   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   mpd_pkg::byte_type  wr_data;
   logic               rd_en;
   logic               out_load;
   mpd_pkg::kind_type  out_kind;
   mpd_pkg::byte_type  out_byte;
   logic               out_last;

   assign out_free     = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready = (state_ff == ST_IDLE) && out_free;
   assign accept       = req_if.valid && req_if.ready;
   assign rx           = req_if.rx_byte;
   assign wr_addr      = count_ff[ADDR_W-1:0];

   assign need_one = {1'b0, count_ff} + (CNT_W + 1)'(1);
   assign need_two = {1'b0, count_ff} + (CNT_W + 1)'(2);
   // A held 'F' plus the new byte need two free entries.
   assign too_long = trl_half_ff ? (need_two > (CNT_W + 1)'(mpd_pkg::MAX_PAYLOAD))
                                 : (need_one > (CNT_W + 1)'(mpd_pkg::MAX_PAYLOAD));

   always_comb begin
      state_in      = state_ff;
      in_payload_in = in_payload_ff;
      hdr_half_in   = hdr_half_ff;
      trl_half_in   = trl_half_ff;
      count_in      = count_ff;
      seen_in       = seen_ff;
      first_in      = first_ff;
      last_in       = last_ff;
      rd_ptr_in     = rd_ptr_ff;
      hold_in       = hold_ff;
      wr_en         = 1'b0;
      wr_data       = rx;
      rd_en         = 1'b0;
      out_load      = 1'b0;
      out_kind      = mpd_pkg::KIND_BYTE;
      out_byte      = 8'd0;
      out_last      = 1'b1;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (!in_payload_ff) begin
                  if (rx == mpd_pkg::CHAR_Z) begin
                     if (hdr_half_ff) begin
                        in_payload_in = 1'b1;
                        hdr_half_in   = 1'b0;
                        trl_half_in   = 1'b0;
                        count_in      = '0;
                        seen_in       = 1'b0;
                     end else begin
                        hdr_half_in = 1'b1;
                     end
                  end else begin
                     hdr_half_in = 1'b0;
                  end
               end else if (rx == mpd_pkg::CHAR_F) begin
                  if (trl_half_ff) begin
                     in_payload_in = 1'b0;
                     trl_half_in   = 1'b0;
                     count_in      = '0;
                     seen_in       = 1'b0;
                     if (seen_ff) begin
                        rd_ptr_in = first_ff;
                        state_in  = ST_RD;
                     end else begin
                        out_load = 1'b1;
                        out_kind = mpd_pkg::KIND_EMPTY;
                     end
                  end else begin
                     trl_half_in = 1'b1;
                  end
               end else if (too_long) begin
                  out_load      = 1'b1;
                  out_kind      = mpd_pkg::KIND_TOO_LONG;
                  in_payload_in = 1'b0;
                  hdr_half_in   = 1'b0;
                  trl_half_in   = 1'b0;
                  count_in      = '0;
                  seen_in       = 1'b0;
               end else if (trl_half_ff) begin
                  wr_en       = 1'b1;
                  wr_data     = mpd_pkg::CHAR_F;
                  trl_half_in = 1'b0;
                  hold_in     = rx;
                  state_in    = ST_WR2;
               end else begin
                  wr_en = 1'b1;
               end
            end
         end
         ST_WR2: begin
            wr_en    = 1'b1;
            wr_data  = hold_ff;
            state_in = ST_IDLE;
         end
         ST_RD: begin
            rd_en    = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_free) begin
               out_load = 1'b1;
               out_byte = rd_data_ff;
               out_last = (rd_ptr_ff == last_ff);
               if (rd_ptr_ff == last_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  rd_ptr_in = rd_ptr_ff + ADDR_W'(1);
                  state_in  = ST_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Track the trimmed span as the payload is written.
      if (wr_en) begin
         count_in = count_ff + CNT_W'(1);
         if (!mpd_pkg::is_blank(wr_data)) begin
            last_in = wr_addr;
            seen_in = 1'b1;
            if (!seen_ff) begin
               first_in = wr_addr;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         in_payload_ff <= 1'b0;
         hdr_half_ff   <= 1'b0;
         trl_half_ff   <= 1'b0;
         count_ff      <= '0;
         seen_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         in_payload_ff <= in_payload_in;
         hdr_half_ff   <= hdr_half_in;
         trl_half_ff   <= trl_half_in;
         count_ff      <= count_in;
         seen_ff       <= seen_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      first_ff  <= first_in;
      last_ff   <= last_in;
      rd_ptr_ff <= rd_ptr_in;
      hold_ff   <= hold_in;
      if (out_load) begin
         rsp_kind_ff <= out_kind;
         rsp_byte_ff <= out_byte;
         rsp_last_ff <= out_last;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         payload_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= payload_mem[rd_ptr_ff];
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.kind         = rsp_kind_ff;
   assign rsp_if.payload_byte = rsp_byte_ff;
   assign rsp_if.last         = rsp_last_ff;

   `MPD_ASSERT_NOW(a_wr_in_range, clock, reset, wr_en,
      count_ff < CNT_W'(mpd_pkg::MAX_PAYLOAD))
   `MPD_ASSERT_NEXT(a_rd_then_out, clock, reset, state_ff == ST_RD, state_ff == ST_OUT)
   `MPD_ASSERT_NOW(a_replay_hunting, clock, reset,
      (state_ff == ST_RD) || (state_ff == ST_OUT), !in_payload_ff && !seen_ff)
   `MPD_ASSERT_NOW(a_rd_ptr_bound, clock, reset, state_ff == ST_RD, rd_ptr_ff <= last_ff)

endmodule

`default_nettype wire
